// ----- src/spl_pkg.sv -----
// Shared types and constants for the sorted priority list.
// Used by spl_cell, sorted_priority_list_core and the testbench; depends on nothing.
package spl_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 16;
    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    localparam logic [2:0] FUNC_PUSH     = 3'd0;
    localparam logic [2:0] FUNC_POP_HEAD = 3'd1;
    localparam logic [2:0] FUNC_POP_TAIL = 3'd2;
    localparam logic [2:0] FUNC_FIND     = 3'd3;
    localparam logic [2:0] FUNC_REMOVE   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]          func;
        logic [KEY_BITS-1:0] entry_priority;
        logic [KEY_BITS-1:0] entry_value;
    } spl_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] out_priority;
        logic [KEY_BITS-1:0] out_value;
        logic [OCC_BITS-1:0] occupancy;
    } spl_rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP_HEAD,
        CELL_POP_TAIL,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] prio;
        logic [KEY_BITS-1:0] value;
    } spl_entry_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t            op;
        logic                tail_side;
        logic [KEY_BITS-1:0] key_prio;
        logic [KEY_BITS-1:0] key_value;
    } spl_cell_ctrl_t;

endpackage

// ----- src/spl_cell.sv -----
// One slot of the sorted list: holds an entry and shifts with its neighbors.
// Depends on spl_pkg.
module spl_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  spl_pkg::spl_cell_ctrl_t ctrl,
    input  logic                    remove_sel,
    input  spl_pkg::spl_entry_t     left_entry,
    input  logic                    left_ge,
    input  spl_pkg::spl_entry_t     right_entry,
    input  logic                    right_le,
    output spl_pkg::spl_entry_t     entry,
    output logic                    le,
    output logic                    ge
);
    import spl_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] prio_reg;
    logic [KEY_BITS-1:0] prio_next;
    logic [KEY_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0] value_next;
    logic                lt;
    logic                eq;

    assign lt = valid_reg && (prio_reg < ctrl.key_prio);
    assign le = valid_reg && (prio_reg <= ctrl.key_prio);
    assign eq = valid_reg && (prio_reg == ctrl.key_prio);

    // ge: this slot is at or after the insert point.
    // Tail side lands before the last equal priority when one exists.
    assign ge = ctrl.tail_side ? (!le || (eq && !right_le)) : !lt;

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        value_next = value_reg;
        case (ctrl.op)
            CELL_PUSH:
            begin
                if (ge)
                begin
                    valid_next = valid_reg || left_entry.valid || !left_ge;
                    if (left_ge)
                    begin
                        prio_next  = left_entry.prio;
                        value_next = left_entry.value;
                    end
                    else
                    begin
                        prio_next  = ctrl.key_prio;
                        value_next = ctrl.key_value;
                    end
                end
            end
            CELL_POP_HEAD:
            begin
                valid_next = right_entry.valid;
                prio_next  = right_entry.prio;
                value_next = right_entry.value;
            end
            CELL_POP_TAIL:
            begin
                valid_next = right_entry.valid;
            end
            CELL_REMOVE:
            begin
                if (remove_sel)
                begin
                    valid_next = right_entry.valid;
                    prio_next  = right_entry.prio;
                    value_next = right_entry.value;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.prio  = prio_reg;
    assign entry.value = value_reg;

endmodule

// ----- src/sorted_priority_list_core.sv -----
// Top level of the sorted priority list: sequencer plus a row of spl_cell slots.
// Depends on spl_pkg and spl_cell.
//
// Usage:
//   Present an item on req and raise start; it is taken at a clock edge where
//   busy is low. busy stays high while the item is worked on.
//   Each item gives exactly one result on rsp, valid for the single cycle in
//   which done is high. The receiver cannot stall; it must take rsp then.
//   The steps run in order: S_ENDS reads the head and tail slots, S_DIR picks
//   the search side and isolates the matching slot with one wide add, S_EXEC
//   shifts all slots in parallel, and the result is then registered and shown
//   on rsp. A new item is not taken until the previous one is finished.
//   busy drops in the cycle that done rises, so the next item can be taken
//   at the edge that ends the cycle in which the previous result is shown.
//   Reset (rst_n low, asynchronous) empties the list; no clearing pass is
//   needed, since each slot carries its own valid bit.
//   Slot contents are undefined until written and are never shown unless
//   held by a valid slot.
module sorted_priority_list_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spl_pkg::spl_req_t req,
    output logic              done,
    output spl_pkg::spl_rsp_t rsp
);
    import spl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENDS,
        S_DIR,
        S_EXEC
    } state_t;

    state_t              state_reg;
    spl_req_t            cmd_reg;
    logic [OCC_BITS-1:0] count_reg;
    logic [OCC_BITS-1:0] count_next;
    spl_entry_t          head_reg;
    spl_entry_t          tail_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] oh_reg;
    logic                tail_side_reg;
    logic                done_reg;
    spl_rsp_t            rsp_reg;
    spl_rsp_t            rsp_next;

    spl_cell_ctrl_t      ctrl;
    spl_entry_t          cell_entry [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] le_vec;
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY-1:0] remove_mask;
    logic [CAPACITY-1:0] match_now;
    logic [CAPACITY-1:0] tail_oh;
    spl_entry_t          tail_pick;
    spl_entry_t          found;
    logic                tail_side_next;
    logic [KEY_BITS-1:0] end_lo;
    logic [KEY_BITS-1:0] end_hi;
    logic [KEY_BITS-1:0] key_now;

    function automatic logic [KEY_BITS-1:0] key_dist(
        input logic [KEY_BITS-1:0] a,
        input logic [KEY_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [CAPACITY-1:0] lowest_one(input logic [CAPACITY-1:0] m);
        return m & (~m + CAPACITY'(1));
    endfunction

    function automatic logic [CAPACITY-1:0] bit_reverse(input logic [CAPACITY-1:0] m);
        logic [CAPACITY-1:0] r;
        for (int i = 0; i < CAPACITY; i++)
        begin
            r[i] = m[CAPACITY-1-i];
        end
        return r;
    endfunction

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spl_entry_t left_entry;
        spl_entry_t right_entry;
        logic       left_ge;
        logic       right_le;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_ge    = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_entry = cell_entry[i-1];
            assign left_ge    = ge_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
            assign right_le    = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_entry = cell_entry[i+1];
            assign right_le    = le_vec[i+1];
        end

        spl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .remove_sel (remove_mask[i]),
            .left_entry (left_entry),
            .left_ge    (left_ge),
            .right_entry(right_entry),
            .right_le   (right_le),
            .entry      (cell_entry[i]),
            .le         (le_vec[i]),
            .ge         (ge_vec[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
        assign match_now[i] = cell_entry[i].valid && (cell_entry[i].value == cmd_reg.entry_value);
    end

    // tail slot is the last valid one
    assign tail_oh = valid_vec & ~(valid_vec >> 1);

    always_comb
    begin
        tail_pick = '0;
        found     = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (tail_oh[i])
            begin
                tail_pick = tail_pick | cell_entry[i];
            end
            if (oh_reg[i])
            begin
                found = found | cell_entry[i];
            end
        end
    end

    // search side: tail when its end lies strictly closer, head on a tie
    always_comb
    begin
        if (cmd_reg.func == FUNC_PUSH)
        begin
            end_lo  = head_reg.prio;
            end_hi  = tail_reg.prio;
            key_now = cmd_reg.entry_priority;
        end
        else
        begin
            end_lo  = head_reg.value;
            end_hi  = tail_reg.value;
            key_now = cmd_reg.entry_value;
        end
        tail_side_next = key_dist(end_lo, key_now) > key_dist(end_hi, key_now);
    end

    // slots at and after the removed one pull from the right
    assign remove_mask = ~(oh_reg - CAPACITY'(1));

    // ---------------- per-item decision ----------------
    always_comb
    begin
        ctrl.op        = CELL_HOLD;
        ctrl.tail_side = tail_side_reg;
        ctrl.key_prio  = cmd_reg.entry_priority;
        ctrl.key_value = cmd_reg.entry_value;
        count_next     = count_reg;
        rsp_next       = '0;
        rsp_next.status = STATUS_OK;

        case (cmd_reg.func)
            FUNC_PUSH:
            begin
                if (count_reg == OCC_BITS'(CAPACITY))
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else
                begin
                    rsp_next.out_priority = cmd_reg.entry_priority;
                    rsp_next.out_value    = cmd_reg.entry_value;
                    count_next            = count_reg + OCC_BITS'(1);
                    ctrl.op               = CELL_PUSH;
                end
            end
            FUNC_POP_HEAD, FUNC_POP_TAIL:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else if (cmd_reg.func == FUNC_POP_HEAD)
                begin
                    rsp_next.out_priority = head_reg.prio;
                    rsp_next.out_value    = head_reg.value;
                    count_next            = count_reg - OCC_BITS'(1);
                    ctrl.op               = CELL_POP_HEAD;
                end
                else
                begin
                    rsp_next.out_priority = tail_reg.prio;
                    rsp_next.out_value    = tail_reg.value;
                    count_next            = count_reg - OCC_BITS'(1);
                    ctrl.op               = CELL_POP_TAIL;
                end
            end
            FUNC_FIND, FUNC_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else if (oh_reg == '0)
                begin
                    rsp_next.status = STATUS_NOTFOUND;
                end
                else
                begin
                    rsp_next.out_priority = found.prio;
                    rsp_next.out_value    = found.value;
                    if (cmd_reg.func == FUNC_REMOVE)
                    begin
                        count_next = count_reg - OCC_BITS'(1);
                        ctrl.op    = CELL_REMOVE;
                    end
                end
            end
            default:
            begin
                rsp_next.status = STATUS_OK;
            end
        endcase

        if (state_reg != S_EXEC)
        begin
            ctrl.op = CELL_HOLD;
        end
        rsp_next.occupancy = count_next;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            cmd_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            match_reg     <= '0;
            oh_reg        <= '0;
            tail_side_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= req;
                        state_reg <= S_ENDS;
                    end
                end
                S_ENDS:
                begin
                    head_reg  <= cell_entry[0];
                    tail_reg  <= tail_pick;
                    match_reg <= match_now;
                    state_reg <= S_DIR;
                end
                S_DIR:
                begin
                    tail_side_reg <= tail_side_next;
                    if (tail_side_next)
                    begin
                        oh_reg <= bit_reverse(lowest_one(bit_reverse(match_reg)));
                    end
                    else
                    begin
                        oh_reg <= lowest_one(match_reg);
                    end
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    count_reg <= count_next;
                    rsp_reg   <= rsp_next;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCC_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("valid slots disagree with entry count");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tail_oh))
        else $error("valid slots are not a contiguous prefix");

    a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(oh_reg))
        else $error("more than one slot selected");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a finished item");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_ENDS))
        else $error("accepted item did not start");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for sorted_priority_list_core: directed table, then random phases.
// Depends on spl_pkg and the core; a behavioral list model predicts each result not given in the table.
`timescale 1ns / 100ps

module testbench;
    import spl_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL   = 150;     // final items sent without gaps
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        spl_req_t item;
        bit       typed;
        spl_rsp_t want;
    } plan_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    spl_req_t req;
    logic     done;
    spl_rsp_t rsp;

    // list model state
    logic [KEY_BITS-1:0] list_prio [CAPACITY];
    logic [KEY_BITS-1:0] list_val  [CAPACITY];
    int                  list_len;

    spl_rsp_t  pending_rsp [$];
    plan_row_t plan [$];
    spl_rsp_t  rsp_want;
    int        fail_count;
    int        cycle_count;
    int        results_seen;
    int        full_seen;
    int        empty_seen;
    int        notfound_seen;
    int        items_sent;

    sorted_priority_list_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    function automatic logic [KEY_BITS-1:0] key_gap(input logic [KEY_BITS-1:0] a,
                                                    input logic [KEY_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // head search finds the first match, tail search the last
    function automatic int value_slot(input logic [KEY_BITS-1:0] v);
        int i;
        if (key_gap(list_val[0], v) > key_gap(list_val[list_len-1], v))
        begin
            for (i = list_len - 1; i >= 0; i--)
                if (list_val[i] == v)
                    return i;
        end
        else
        begin
            for (i = 0; i < list_len; i++)
                if (list_val[i] == v)
                    return i;
        end
        return -1;
    endfunction

    function automatic spl_rsp_t list_apply(input spl_req_t item);
        spl_rsp_t            res;
        int                  pos;
        int                  i;
        logic [KEY_BITS-1:0] np;
        np  = item.entry_priority;
        res = '0;
        res.status = STATUS_OK;
        pos = 0;
        case (item.func)
            FUNC_PUSH:
            begin
                if (list_len >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                begin
                    if (list_len == 0)
                        pos = 0;
                    else if (key_gap(list_prio[0], np) > key_gap(list_prio[list_len-1], np))
                    begin
                        i = list_len - 1;
                        while (i > 0 && list_prio[i] > np)
                            i--;
                        pos = (list_prio[i] < np) ? i + 1 : i;
                    end
                    else
                    begin
                        i = 0;
                        while (i + 1 < list_len && list_prio[i] < np)
                            i++;
                        pos = (list_prio[i] < np) ? i + 1 : i;
                    end
                    for (i = list_len; i > pos; i--)
                    begin
                        list_prio[i] = list_prio[i-1];
                        list_val[i]  = list_val[i-1];
                    end
                    list_prio[pos] = np;
                    list_val[pos]  = item.entry_value;
                    list_len++;
                    res.out_priority = np;
                    res.out_value    = item.entry_value;
                end
            end
            FUNC_POP_HEAD, FUNC_POP_TAIL:
            begin
                if (list_len == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    pos = (item.func == FUNC_POP_HEAD) ? 0 : list_len - 1;
                    res.out_priority = list_prio[pos];
                    res.out_value    = list_val[pos];
                    for (i = pos; i + 1 < list_len; i++)
                    begin
                        list_prio[i] = list_prio[i+1];
                        list_val[i]  = list_val[i+1];
                    end
                    list_len--;
                end
            end
            FUNC_FIND, FUNC_REMOVE:
            begin
                if (list_len == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    pos = value_slot(item.entry_value);
                    if (pos < 0)
                        res.status = STATUS_NOTFOUND;
                    else
                    begin
                        res.out_priority = list_prio[pos];
                        res.out_value    = list_val[pos];
                        if (item.func == FUNC_REMOVE)
                        begin
                            for (i = pos; i + 1 < list_len; i++)
                            begin
                                list_prio[i] = list_prio[i+1];
                                list_val[i]  = list_val[i+1];
                            end
                            list_len--;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_BITS'(list_len);
        return res;
    endfunction

    function automatic spl_rsp_t make_rsp(input logic [1:0] st, input logic [KEY_BITS-1:0] p,
                                          input logic [KEY_BITS-1:0] v, input int occ);
        spl_rsp_t r;
        r.status       = st;
        r.out_priority = p;
        r.out_value    = v;
        r.occupancy    = OCC_BITS'(occ);
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] f, input logic [KEY_BITS-1:0] p,
                                    input logic [KEY_BITS-1:0] v, input bit typed,
                                    input spl_rsp_t want);
        plan_row_t row;
        row.item.func           = f;
        row.item.entry_priority = p;
        row.item.entry_value    = v;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_priority();
        case ($urandom_range(0, 4))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    default: return 16'h8000;
                endcase
            end
            1: return KEY_BITS'($urandom_range(0, 15));
            2:
            begin
                // reuse a held priority so ties land on both search sides
                if (list_len > 0)
                    return list_prio[$urandom_range(0, list_len - 1)];
                return KEY_BITS'($urandom);
            end
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_value(input logic [2:0] f);
        int r;
        r = $urandom_range(0, 99);
        if ((f == FUNC_FIND || f == FUNC_REMOVE) && list_len > 0 && r < 60)
            return list_val[$urandom_range(0, list_len - 1)];
        if (r < 75)
            return KEY_BITS'($urandom_range(0, 7));
        if (r < 80)
            return 16'hFFFF;
        return KEY_BITS'($urandom);
    endfunction

    // phase: 0 fill, 1 drain, 2 mixed
    function automatic spl_req_t random_item(input int phase);
        spl_req_t item;
        int       r;
        int       push_pct;
        r = $urandom_range(0, 99);
        push_pct = (phase == 0) ? 80 : (phase == 1) ? 15 : 50;
        if (r < 3)
            item.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else if (r < 3 + push_pct)
            item.func = FUNC_PUSH;
        else
            item.func = 3'($urandom_range(FUNC_POP_HEAD, FUNC_REMOVE));
        item.entry_priority = (item.func == FUNC_PUSH) ? pick_priority() : KEY_BITS'($urandom);
        item.entry_value    = pick_value(item.func);
        return item;
    endfunction

    task automatic send_item(input spl_req_t item, input bit typed, input spl_rsp_t want);
        spl_rsp_t predicted;
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = list_apply(item);
        pending_rsp.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 13))
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with nothing pending: %p", rsp);
                fail_count++;
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                results_seen++;
                if (rsp.status != rsp_want.status)
                begin
                    $error("status: expected %0d, got %0d", rsp_want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_priority != rsp_want.out_priority)
                begin
                    $error("out_priority: expected %h, got %h",
                           rsp_want.out_priority, rsp.out_priority);
                    fail_count++;
                end
                if (rsp.out_value != rsp_want.out_value)
                begin
                    $error("out_value: expected %h, got %h", rsp_want.out_value, rsp.out_value);
                    fail_count++;
                end
                if (rsp.occupancy != rsp_want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           rsp_want.occupancy, rsp.occupancy);
                    fail_count++;
                end
                if (rsp_want.status == STATUS_FULL)
                    full_seen++;
                if (rsp_want.status == STATUS_EMPTY)
                    empty_seen++;
                if (rsp_want.status == STATUS_NOTFOUND)
                    notfound_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_rsp.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int phase_len;
        int k;
        int random_done;
        bit quiet;
        spl_req_t item;

        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        list_len      = 0;
        fail_count    = 0;
        cycle_count   = 0;
        results_seen  = 0;
        full_seen     = 0;
        empty_seen    = 0;
        notfound_seen = 0;
        items_sent    = 0;
        random_done   = 0;

        // empty-list errors, unused codes, extreme keys, priority ties, duplicate values
        add_row(FUNC_POP_HEAD,  16'h0000, 16'h0000, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));
        add_row(FUNC_POP_TAIL,  16'hFFFF, 16'hFFFF, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));
        add_row(FUNC_FIND,      16'h0000, 16'h1234, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));
        add_row(FUNC_REMOVE,    16'h0000, 16'h1234, 1, make_rsp(STATUS_EMPTY, 0, 0, 0));
        add_row(FUNC_UNUSED_LO, 16'hFFFF, 16'hFFFF, 1, make_rsp(STATUS_OK, 0, 0, 0));
        add_row(FUNC_PUSH, 16'h8000, 16'h0001, 1, make_rsp(STATUS_OK, 16'h8000, 16'h0001, 1));
        add_row(FUNC_PUSH, 16'h0000, 16'hFFFF, 1, make_rsp(STATUS_OK, 16'h0000, 16'hFFFF, 2));
        add_row(FUNC_PUSH, 16'hFFFF, 16'h0000, 1, make_rsp(STATUS_OK, 16'hFFFF, 16'h0000, 3));
        add_row(FUNC_PUSH, 16'h8000, 16'h0002, 0, '0);
        add_row(FUNC_PUSH, 16'h8000, 16'h0003, 0, '0);
        add_row(FUNC_PUSH, 16'h7FFF, 16'hAAAA, 0, '0);
        add_row(FUNC_PUSH, 16'h8001, 16'h5555, 0, '0);
        add_row(FUNC_UNUSED_HI, 16'h5A5A, 16'hA5A5, 1, make_rsp(STATUS_OK, 0, 0, 7));
        add_row(FUNC_FIND,   16'h0000, 16'h0002, 0, '0);
        add_row(FUNC_FIND,   16'h0000, 16'hBEEF, 1, make_rsp(STATUS_NOTFOUND, 0, 0, 7));
        add_row(FUNC_REMOVE, 16'h0000, 16'hBEEF, 1, make_rsp(STATUS_NOTFOUND, 0, 0, 7));
        add_row(FUNC_FIND,   16'h0000, 16'hFFFF, 0, '0);
        add_row(FUNC_PUSH,   16'h0010, 16'h0001, 0, '0);
        add_row(FUNC_FIND,   16'h0000, 16'h0001, 0, '0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0001, 0, '0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0003, 0, '0);
        add_row(FUNC_POP_HEAD, 16'h0000, 16'h0000, 0, '0);
        add_row(FUNC_POP_TAIL, 16'h0000, 16'h0000, 0, '0);

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_gap();
            send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        while (random_done < RANDOM_ITEMS)
        begin
            phase     = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 100);
            quiet     = ($urandom_range(0, 3) == 0);
            for (k = 0; k < phase_len && random_done < RANDOM_ITEMS; k++)
            begin
                item = random_item(phase);
                if (!quiet && random_done < RANDOM_ITEMS - QUIET_TAIL
                    && $urandom_range(0, 5) == 0)
                    idle_gap();
                send_item(item, 0, '0);
                if (item.func <= FUNC_REMOVE)
                    random_done++;
            end
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("sent %0d items, checked %0d results", items_sent, results_seen);
        $display("full %0d, empty %0d, not found %0d; %0d mismatches",
                 full_seen, empty_seen, notfound_seen, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/spl_pkg.sv
src/spl_cell.sv
src/sorted_priority_list_core.sv
test/testbench.sv
